// ===== rtl/asfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the adaptive symbol frequency model.
// Used by asfm_seq and the top level; no dependencies.
package asfm_pkg;

    localparam int CNT_W    = 32;
    localparam int WEIGHT_W = 16;
    localparam int SYM_W    = 8;

    localparam logic [CNT_W-1:0]    COUNT_MAX    = '1;
    localparam logic [CNT_W-1:0]    COUNT_RESET  = 32'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd32;

    // Item kinds carried on the input tuser
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] cumulative;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] peak;
        logic             saturated;
    } t_result;

endpackage

// ===== rtl/asfm_count_ram.sv =====
`timescale 1ns / 1ps
// Per-symbol count memory: one write port, one read port, registered read data.
// No dependencies.
module asfm_count_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/asfm_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the frequency model: clearing pass, cumulative sum over the
// count memory, read-modify-write of one count, total and peak. Uses asfm_pkg.
module asfm_seq #(
    parameter int SYMBOLS = 256,
    parameter int AW      = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [asfm_pkg::SYM_W-1:0]     i_symbol,
    input  logic [asfm_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                           o_res_vld,
    input  logic                           i_res_rdy,
    output asfm_pkg::t_result              o_res,
    output logic                           o_rd_en,
    output logic [AW-1:0]                  o_rd_addr,
    input  logic [asfm_pkg::CNT_W-1:0]     i_rd_data,
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [asfm_pkg::CNT_W-1:0]     o_wr_data
);
    import asfm_pkg::*;

    localparam int CW = $clog2(SYMBOLS + 1);
    localparam int LW = (CW > SYM_W) ? CW : SYM_W;

    t_state r_state, n_state;

    logic [LW-1:0]    r_cnt, n_cnt;
    logic [LW-1:0]    r_lim, n_lim;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_addr, n_addr;
    logic [CNT_W-1:0] r_cum, n_cum;
    logic             r_sat, n_sat;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_peak, n_peak;

    logic [LW-1:0]    sym_ext;
    logic             in_range;
    logic [LW-1:0]    limit;
    logic             accept;
    logic             issue;
    logic [CNT_W:0]   cum_sum;
    logic [CNT_W:0]   cnt_sum;
    logic [CNT_W:0]   tot_sum;
    logic [CNT_W-1:0] new_count;
    logic [CNT_W-1:0] new_total;

    // Decode the incoming item
    always_comb begin
        sym_ext  = LW'(i_symbol);
        in_range = sym_ext < LW'(SYMBOLS);
        limit    = in_range ? sym_ext : LW'(SYMBOLS);
        accept   = i_valid && (r_state == ST_IDLE);
        issue    = r_cnt != r_lim;
    end

    // Saturating adders
    always_comb begin
        cum_sum   = {1'b0, r_cum} + {1'b0, i_rd_data};
        cnt_sum   = {1'b0, i_rd_data} + (CNT_W + 1)'(i_weight);
        tot_sum   = {1'b0, r_total} + (CNT_W + 1)'(i_weight);
        new_count = cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];
        new_total = tot_sum[CNT_W] ? COUNT_MAX : tot_sum[CNT_W-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == LW'(SYMBOLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_UPDATE && in_range) begin
                        n_state = ST_UPD;
                    end else if (i_op == OP_QUERY && limit != '0) begin
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SUM: begin
                if (!issue && r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_UPD: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_rdy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Memory requests and handshake outputs
    always_comb begin
        o_ready   = 1'b0;
        o_res_vld = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = sym_ext[AW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_addr;
        o_wr_data = new_count;
        case (r_state)
            ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cnt[AW-1:0];
                o_wr_data = COUNT_RESET;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                o_rd_en = accept && i_op == OP_UPDATE && in_range;
            end
            ST_SUM: begin
                o_rd_en   = issue;
                o_rd_addr = r_cnt[AW-1:0];
            end
            ST_UPD: begin
                o_wr_en = 1'b1;
            end
            ST_DONE: begin
                o_res_vld = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_cnt   = r_cnt;
        n_lim   = r_lim;
        n_pend  = r_pend;
        n_addr  = r_addr;
        n_cum   = r_cum;
        n_sat   = r_sat;
        n_total = r_total;
        n_peak  = r_peak;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + LW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cnt  = '0;
                    n_pend = 1'b0;
                    n_lim  = limit;
                    n_addr = sym_ext[AW-1:0];
                    n_cum  = '0;
                    n_sat  = 1'b0;
                end
            end
            ST_SUM: begin
                // Issue one read per cycle, fold in the data of the previous one
                if (issue) begin
                    n_cnt = r_cnt + LW'(1);
                end
                n_pend = issue;
                if (r_pend) begin
                    n_cum = cum_sum[CNT_W] ? COUNT_MAX : cum_sum[CNT_W-1:0];
                    n_sat = r_sat | cum_sum[CNT_W];
                end
            end
            ST_UPD: begin
                n_total = new_total;
                n_peak  = (new_total > r_peak) ? new_total : r_peak;
                n_sat   = cnt_sum[CNT_W] | tot_sum[CNT_W];
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_total <= CNT_W'(SYMBOLS);
            r_peak  <= CNT_W'(SYMBOLS);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_total <= n_total;
            r_peak  <= n_peak;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lim  <= n_lim;
        r_addr <= n_addr;
        r_cum  <= n_cum;
        r_sat  <= n_sat;
    end

    assign o_res.cumulative = r_cum;
    assign o_res.total      = r_total;
    assign o_res.peak       = r_peak;
    assign o_res.saturated  = r_sat;

endmodule

// ===== rtl/adaptive_symbol_frequency_model_unit.sv =====
`timescale 1ns / 1ps
// Top level of the adaptive symbol frequency model: stream ports, weight
// register, output register. Uses asfm_pkg, asfm_count_ram and asfm_seq.

// The block keeps one saturating 32-bit count per symbol in a single-port-read
// memory, plus the running total and the peak total. After reset a clearing
// pass writes 1 into every count, one entry per cycle; o_s_tready stays low
// until it ends. One item is worked at a time. A query for symbol s reads the
// counts below s one per cycle through the memory read port; an update reads
// the count, adds the weight and writes it back; a query of symbol 0 or an
// update of a symbol outside the table reads no count. The result waits in an
// output register, so the next item is taken while it is still unread. Write
// the weight only while the block is idle.
module adaptive_symbol_frequency_model_unit #(
    parameter int SYMBOLS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: weight register
    input  logic                               i_cfg_wr_en,
    input  logic [asfm_pkg::WEIGHT_W-1:0]      i_cfg_wr_data,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] symbol
    input  logic                               i_s_tuser,   // [0] op
    // Output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [95:0]                        o_m_tdata,   // [31:0] cumulative,
                                                            // [63:32] total,
                                                            // [95:64] peak
    output logic                               o_m_tuser    // [0] saturated
);
    import asfm_pkg::*;

    localparam int AW = $clog2(SYMBOLS);

    logic [WEIGHT_W-1:0] r_weight;
    logic                r_out_vld;
    t_result             r_out;

    logic                res_vld;
    logic                res_rdy;
    t_result             res;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [CNT_W-1:0]    rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CNT_W-1:0]    wr_data;

    // Weight register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_weight <= i_cfg_wr_data;
        end
    end

    asfm_count_ram #(
        .DEPTH (SYMBOLS),
        .AW    (AW),
        .DW    (CNT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    asfm_seq #(
        .SYMBOLS (SYMBOLS),
        .AW      (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_op      (i_s_tuser),
        .i_symbol  (i_s_tdata),
        .i_weight  (r_weight),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // Output register: load when empty or being drained
    assign res_rdy = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out.peak, r_out.total, r_out.cumulative};
    assign o_m_tuser  = r_out.saturated;

    // The peak never falls below the running total
    a_peak_ge_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.peak >= res.total)
        else $error("peak total below running total");

    // Only one item is worked at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second transfer taken while an item is in work");

    // A clamped nonzero cumulative sum sits at the top of the range
    a_cum_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.saturated && res.cumulative != '0) |-> (res.cumulative == COUNT_MAX))
        else $error("saturated cumulative sum not clamped");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of adaptive_symbol_frequency_model_unit: a directed table,
// random phases at several weights and a short run at the largest weight; unpinned items
// checked against an in-bench frequency model. Depends on rtl/asfm_pkg.sv and the RTL.
module tb_top;
    import asfm_pkg::*;

    localparam int NUM_SYMBOLS   = 256;
    localparam int STALL_LIMIT   = 8000;
    localparam int RX_HOLD       = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 40;
    localparam int PHASES        = 5;
    localparam int DIR_ROWS      = 23;

    // One row of the directed table; want is used only when pinned is set
    typedef struct packed {
        logic              op;
        logic [SYM_W-1:0]  sym;
        logic              pinned;
        t_result           want;
    } t_dir_row;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [WEIGHT_W-1:0] i_cfg_wr_data = '0;
    logic                i_s_tvalid    = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata     = '0;   // [7:0] symbol
    logic                i_s_tuser     = 1'b0; // [0] op
    logic                o_m_tvalid;
    logic                i_m_tready    = 1'b0;
    logic [95:0]         o_m_tdata;            // [31:0] cumulative, [63:32] total,
                                               // [95:64] peak
    logic                o_m_tuser;            // [0] saturated

    // Model of the frequency table
    logic [CNT_W-1:0]    sym_count [NUM_SYMBOLS];
    logic [CNT_W-1:0]    count_total;
    logic [CNT_W-1:0]    count_peak;
    logic [WEIGHT_W-1:0] cur_weight;

    t_result             pending_results [$];
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;
    bit                  tx_eager       = 1'b0;
    bit                  rx_eager       = 1'b0;
    bit                  rx_hold_req    = 1'b0;

    t_dir_row directed_rows [DIR_ROWS] = '{
        '{OP_QUERY,  8'h00, 1'b1, '{32'd0,   32'd256, 32'd256, 1'b0}},
        '{OP_QUERY,  8'hFF, 1'b1, '{32'd255, 32'd256, 32'd256, 1'b0}},
        '{OP_QUERY,  8'h01, 1'b1, '{32'd1,   32'd256, 32'd256, 1'b0}},
        '{OP_QUERY,  8'h80, 1'b1, '{32'd128, 32'd256, 32'd256, 1'b0}},
        '{OP_UPDATE, 8'h00, 1'b1, '{32'd0,   32'd288, 32'd288, 1'b0}},
        '{OP_UPDATE, 8'hFF, 1'b1, '{32'd0,   32'd320, 32'd320, 1'b0}},
        '{OP_QUERY,  8'h01, 1'b1, '{32'd33,  32'd320, 32'd320, 1'b0}},
        '{OP_QUERY,  8'hFF, 1'b1, '{32'd287, 32'd320, 32'd320, 1'b0}},
        '{OP_QUERY,  8'h00, 1'b1, '{32'd0,   32'd320, 32'd320, 1'b0}},
        '{OP_UPDATE, 8'h55, 1'b0, '0},
        '{OP_QUERY,  8'hAA, 1'b0, '0},
        '{OP_UPDATE, 8'hAA, 1'b0, '0},
        '{OP_QUERY,  8'h55, 1'b0, '0},
        '{OP_QUERY,  8'h56, 1'b0, '0},
        '{OP_UPDATE, 8'h80, 1'b0, '0},
        '{OP_QUERY,  8'h7F, 1'b0, '0},
        '{OP_QUERY,  8'h81, 1'b0, '0},
        '{OP_UPDATE, 8'h01, 1'b0, '0},
        '{OP_QUERY,  8'h02, 1'b0, '0},
        '{OP_UPDATE, 8'hFE, 1'b0, '0},
        '{OP_QUERY,  8'hFF, 1'b0, '0},
        '{OP_UPDATE, 8'hFF, 1'b0, '0},
        '{OP_QUERY,  8'hFF, 1'b0, '0}
    };

    adaptive_symbol_frequency_model_unit #(
        .SYMBOLS (NUM_SYMBOLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Add with clamp at the counter top; hit is raised on a clamp
    function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b,
                                                   inout logic hit);
        logic [CNT_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        if (wide[CNT_W]) begin
            hit = 1'b1;
            return COUNT_MAX;
        end
        return wide[CNT_W-1:0];
    endfunction

    // Apply one item to the model table and return the result it causes
    function automatic t_result freq_predict(input logic op, input logic [SYM_W-1:0] sym);
        t_result r;
        logic    hit;
        int      limit;
        r   = '0;
        hit = 1'b0;
        if (op == OP_QUERY) begin
            limit = (int'(sym) < NUM_SYMBOLS) ? int'(sym) : NUM_SYMBOLS;
            for (int i = 0; i < limit; i++)
                r.cumulative = clamp_add(r.cumulative, sym_count[i], hit);
        end else if (int'(sym) < NUM_SYMBOLS) begin
            count_total    = clamp_add(count_total, CNT_W'(cur_weight), hit);
            sym_count[sym] = clamp_add(sym_count[sym], CNT_W'(cur_weight), hit);
            if (count_total > count_peak)
                count_peak = count_total;
        end
        r.total     = count_total;
        r.peak      = count_peak;
        r.saturated = hit;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Idle gaps: mostly none or short, a few long
    function automatic int draw_gap(input bit eager);
        int pick;
        pick = $urandom_range(99);
        if (eager || pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Random item: symbols biased toward short sums and the table ends
    task automatic draw_item(output logic op, output logic [SYM_W-1:0] sym);
        int pick;
        pick = $urandom_range(99);
        op   = 1'($urandom_range(1));
        if (pick < 25)
            sym = SYM_W'($urandom_range(15));
        else if (pick < 35)
            sym = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            sym = SYM_W'($urandom_range(255));
    endtask

    // Offer one item, hold it until the transfer, then record its result
    task automatic send_item(input logic op, input logic [SYM_W-1:0] sym,
                             input logic pinned, input t_result want);
        t_result predicted;
        int      gap;
        gap = draw_gap(tx_eager);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sym;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = freq_predict(op, sym);
        pending_results.push_back(pinned ? want : predicted);
    endtask

    task automatic settle_idle();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_weight     = w;
    endtask

    // Result side: random stalls, a long hold-off on request, or always ready
    initial begin : rx_side
        logic ready;
        int   len;
        wait (i_rst_n);
        forever begin
            if (rx_hold_req) begin
                ready = 1'b0;
                len   = RX_HOLD;
            end else if (rx_eager) begin
                ready = 1'b1;
                len   = 1;
            end else begin
                len   = draw_gap(1'b0);
                ready = (len == 0);
                if (ready)
                    len = $urandom_range(8, 1);
            end
            i_m_tready <= ready;
            repeat (len) @(posedge i_clk);
            if (!ready && len == RX_HOLD)
                rx_hold_req = 1'b0;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing expected", o_m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[31:0] !== want.cumulative)
                    flag_mismatch("cumulative", o_m_tdata[31:0], want.cumulative);
                if (o_m_tdata[63:32] !== want.total)
                    flag_mismatch("total", o_m_tdata[63:32], want.total);
                if (o_m_tdata[95:64] !== want.peak)
                    flag_mismatch("peak", o_m_tdata[95:64], want.peak);
                if (o_m_tuser !== want.saturated)
                    flag_mismatch("saturated", CNT_W'(o_m_tuser), CNT_W'(want.saturated));
            end
        end
    end

    // Stop the run when no transfer happens for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic                op;
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] phase_weight [PHASES];
        int                  phase_items  [PHASES];

        for (int i = 0; i < NUM_SYMBOLS; i++)
            sym_count[i] = COUNT_RESET;
        count_total = CNT_W'(NUM_SYMBOLS);
        count_peak  = CNT_W'(NUM_SYMBOLS);
        cur_weight  = WEIGHT_RESET;

        phase_weight = '{16'd1, 16'hFFFF, 16'd0, 16'(int'($urandom_range(65534, 2))),
                         16'(int'($urandom_range(65534, 2)))};
        phase_items  = '{400, 400, 100, 500, 500};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset weight
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(directed_rows[r].op, directed_rows[r].sym,
                      directed_rows[r].pinned, directed_rows[r].want);
        i_s_tvalid <= 1'b0;

        // Random phases; the fourth fills the block behind a long hold-off,
        // the last runs with no idling on either side
        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            write_weight(phase_weight[p]);
            tx_eager = (p == PHASES - 1);
            rx_eager = (p == PHASES - 1);
            if (p == 3)
                rx_hold_req = 1'b1;
            for (int n = 0; n < phase_items[p]; n++) begin
                draw_item(op, sym);
                send_item(op, sym, 1'b0, '0);
            end
            i_s_tvalid <= 1'b0;
        end

        // Close with a few updates and queries at the largest weight
        settle_idle();
        write_weight(16'hFFFF);
        send_item(OP_UPDATE, 8'h00, 1'b0, '0);
        send_item(OP_UPDATE, 8'h09, 1'b0, '0);
        send_item(OP_QUERY,  8'h00, 1'b0, '0);
        send_item(OP_QUERY,  8'h01, 1'b0, '0);
        send_item(OP_QUERY,  8'h02, 1'b0, '0);
        send_item(OP_QUERY,  8'hFF, 1'b0, '0);
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        send_item(OP_UPDATE, 8'hFF, 1'b0, '0);
        send_item(OP_QUERY,  8'h80, 1'b0, '0);
        i_s_tvalid <= 1'b0;

        settle_idle();
        repeat (16) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", pending_results.size(), '0);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== adaptive_symbol_frequency_model_unit.f =====
rtl/asfm_pkg.sv
rtl/asfm_count_ram.sv
rtl/asfm_seq.sv
rtl/adaptive_symbol_frequency_model_unit.sv
verif/tb_top.sv
